[rtl/b64enc_pkg.sv]
// Package for the base64 stream encoder: types, constants and the alphabet lookup.
package b64enc_pkg;

   localparam int CharWidth    = 7;
   localparam int ByteWidth    = 8;
   localparam int MaxChars     = 4;
   localparam int CharIdxWidth = $clog2(MaxChars);
   localparam int QueueDepth   = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Position within a group of three bytes.
   localparam logic [1:0] PhaseStart = 2'd0;
   localparam logic [1:0] PhaseOne   = 2'd1;
   localparam logic [1:0] PhaseTwo   = 2'd2;

   localparam logic [CharWidth-1:0] PadChar = 7'd61;  // '='

   typedef logic [CharWidth-1:0] char_type;

   // One accepted byte, turned into the characters it produces.
   typedef struct packed {
      char_type [MaxChars-1:0]  chars;
      logic [CharIdxWidth-1:0]  last_idx;   // index of the final character of this job
      logic                     final_job;  // job closes the message
   } job_type;

   // Maps a six-bit value onto the standard alphabet.
   function automatic char_type sextet_char(input logic [5:0] v);
      logic [6:0] code;
      begin
         if (v < 6'd26) begin
            code = 7'd65 + {1'b0, v};
         end else if (v < 6'd52) begin
            code = 7'd97 + {1'b0, v} - 7'd26;
         end else if (v < 6'd62) begin
            code = 7'd48 + {1'b0, v} - 7'd52;
         end else if (v == 6'd62) begin
            code = 7'd43;
         end else begin
            code = 7'd47;
         end
         return code;
      end
   endfunction

endpackage

[rtl/base64_stream_encoder_core.sv]
// Top level of the streaming base64 encoder.
//
// The request channel (req_valid, req_stall, req_data_byte, req_final_byte) takes one raw
// byte per request; req_final_byte marks the last byte of a message. The response channel
// (rsp_valid, rsp_stall, rsp_out_char, rsp_last_char) delivers one ASCII character per
// transfer, with rsp_last_char high on the final character of the message.
// A byte produces one character, or two when it completes a group of three bytes. A final
// byte flushes the partial group and pads it with '=' to four characters in total.
// The front end converts each request into a job of up to four characters in the cycle it
// is accepted and writes it into a two-entry queue. The back end reads the queue head and
// sends one character per cycle, unless the receiver stalls, through an output register,
// so the first character of a request passes the queue entry and then the output register.
// Throughput is set by that output register: an ordinary byte yields one or two characters,
// a final byte two to four. When the receiver stalls, the output register holds its
// character; the queue fills, and req_stall rises once both queue entries are occupied.
// Reset clears the group phase, the leftover bits, the queue and the output valid flag.
module base64_stream_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char
);
   import b64enc_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   job_type push_job;
   job_type head_job;

   // Front end: group phase tracking and character lookup.
   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   // Job queue between the two halves.
   b64enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   // Back end: serializes each job onto the response channel.
   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .empty         (queue_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

[rtl/b64enc_front.sv]
// Front end of the encoder: takes bytes, tracks the group phase and builds character jobs.
module b64enc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_final_byte,
   input  logic                       queue_full,
   output logic                       push,
   output b64enc_pkg::job_type        push_job
);
   import b64enc_pkg::*;

   logic [1:0] group_phase_ff, group_phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic       accept;
   job_type    job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;
   assign push_job  = job;

   always_comb begin
      job            = '0;
      group_phase_in = group_phase_ff;
      leftover_in    = leftover_ff;
      job.final_job  = req_final_byte;
      case (group_phase_ff)
         PhaseOne: begin
            job.chars[0] = sextet_char({leftover_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               job.chars[1] = sextet_char({req_data_byte[3:0], 2'b00});
               job.chars[2] = PadChar;
               job.last_idx = 2'd2;
               group_phase_in = PhaseStart;
               leftover_in    = '0;
            end else begin
               job.last_idx   = 2'd0;
               group_phase_in = PhaseTwo;
               leftover_in    = req_data_byte[3:0];
            end
         end
         PhaseTwo: begin
            job.chars[0] = sextet_char({leftover_ff, req_data_byte[7:6]});
            job.chars[1] = sextet_char(req_data_byte[5:0]);
            job.last_idx = 2'd1;
            group_phase_in = PhaseStart;
            leftover_in    = '0;
         end
         default: begin
            // Start of a group; the unused phase code behaves the same way.
            job.chars[0] = sextet_char(req_data_byte[7:2]);
            if (req_final_byte) begin
               job.chars[1] = sextet_char({req_data_byte[1:0], 4'b0000});
               job.chars[2] = PadChar;
               job.chars[3] = PadChar;
               job.last_idx = 2'd3;
               group_phase_in = PhaseStart;
               leftover_in    = '0;
            end else begin
               job.last_idx   = 2'd0;
               group_phase_in = PhaseOne;
               leftover_in    = {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_phase_ff <= PhaseStart;
         leftover_ff    <= '0;
      end else if (accept) begin
         group_phase_ff <= group_phase_in;
         leftover_ff    <= leftover_in;
      end
   end

endmodule

[rtl/b64enc_queue.sv]
// Short job queue that decouples the front end from the character serializer.
module b64enc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64enc_pkg::job_type  push_job,
   output logic                 full,
   input  logic                 pop,
   output b64enc_pkg::job_type  head_job,
   output logic                 empty
);
   import b64enc_pkg::*;

   job_type                   entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0]  count_ff;

   assign full     = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/b64enc_back.sv]
// Back end: sends each queued job's characters one per cycle while not stalled.
module b64enc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64enc_pkg::job_type  head_job,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_out_char,
   output logic                 rsp_last_char
);
   import b64enc_pkg::*;

   logic [CharIdxWidth-1:0] char_idx_ff;
   logic                    rsp_valid_ff;
   char_type                out_char_ff;
   logic                    last_char_ff;
   logic                    advance;
   logic                    send;
   logic                    job_done;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign send     = advance && !empty;
   assign job_done = (char_idx_ff == head_job.last_idx);
   assign pop      = send && job_done;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = last_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         char_idx_ff  <= '0;
      end else if (advance) begin
         rsp_valid_ff <= !empty;
         if (send) begin
            char_idx_ff <= job_done ? '0 : char_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         out_char_ff  <= head_job.chars[char_idx_ff];
         last_char_ff <= head_job.final_job && job_done;
      end
   end

endmodule

[tb/base64_stream_encoder_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for the streaming base64 encoder: byte messages checked against a local predictor.
module base64_stream_encoder_core_tb;
   import b64enc_pkg::*;

   // Minimum number of bytes sent after the directed messages; the last message is completed.
   localparam int RandomBytes = 350;
   // Cycles without any accepted request or character before the run is declared hung.
   // The longest legal quiet stretch is the forced receiver hold plus one long gap.
   localparam int IdleLimit   = 2000;
   // Length of the forced receiver hold that fills the encoder's queue.
   localparam int HoldCycles  = 300;
   localparam int MaxReports  = 10;

   // One expected output character together with its end-of-message flag.
   typedef struct packed {
      char_type code;
      logic     last;
   } enc_char_type;

   // The scoreboard keeps its own copy of the group phase and the carried bits. Every
   // accepted request is turned into the characters it must produce, and every character
   // leaving the block is compared with the oldest one still due.
   class b64_scoreboard;
      string        alphabet;
      logic [1:0]   phase;
      logic [3:0]   carry_bits;
      enc_char_type chars_due[$];
      int           mismatches;

      function new();
         alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         phase      = PhaseStart;
         carry_bits = 4'd0;
         mismatches = 0;
      endfunction

      function char_type symbol(logic [5:0] v);
         return char_type'(alphabet[v]);
      endfunction

      function int outstanding();
         return chars_due.size();
      endfunction

      // Works out the characters caused by one accepted byte and queues them.
      function void note_request(logic [7:0] data, logic fin);
         char_type     out [4];
         int           n;
         enc_char_type item;
         n = 0;
         case (phase)
            PhaseOne: begin
               out[0] = symbol({carry_bits[1:0], data[7:4]});
               if (fin) begin
                  out[1] = symbol({data[3:0], 2'b00});
                  out[2] = PadChar;
                  n = 3;
               end else begin
                  n = 1;
                  carry_bits = data[3:0];
                  phase = PhaseTwo;
               end
            end
            PhaseTwo: begin
               // The third byte always closes the group, final or not.
               out[0] = symbol({carry_bits, data[7:6]});
               out[1] = symbol(data[5:0]);
               n = 2;
               carry_bits = 4'd0;
               phase = PhaseStart;
            end
            default: begin
               // The unused phase value behaves like the start of a group.
               out[0] = symbol(data[7:2]);
               if (fin) begin
                  out[1] = symbol({data[1:0], 4'b0000});
                  out[2] = PadChar;
                  out[3] = PadChar;
                  n = 4;
               end else begin
                  n = 1;
                  carry_bits = {2'b00, data[1:0]};
                  phase = PhaseOne;
               end
            end
         endcase
         for (int i = 0; i < n; i++) begin
            item.code = out[i];
            item.last = fin && (i == n - 1);
            chars_due.push_back(item);
         end
         if (fin) begin
            phase = PhaseStart;
            carry_bits = 4'd0;
         end
      endfunction

      // Compares one character taken from the block with the oldest one due.
      function void check_char(char_type code, logic last);
         enc_char_type want;
         if (chars_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
               $display("error: character %0d last %0b arrived with nothing due", code, last);
            end
         end else begin
            want = chars_due.pop_front();
            if (want.code !== code || want.last !== last) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("error: expected char %0d last %0b, got char %0d last %0b",
                           want.code, want.last, code, last);
               end
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_final_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;

   b64_scoreboard sb;

   // Traffic shaping shared between the stimulus and the receiver.
   logic hold_req      = 1'b0;  // main flow asks the receiver for one long hold
   bit   hold_taken    = 1'b0;  // receiver has started that hold
   int   burst_left    = 0;     // requests still to be offered back to back
   bit   sender_quiet  = 1'b0;  // current message is sent without gaps
   int   hold_left     = 0;
   int   stall_left    = 0;
   int   rsp_mode_left = 0;
   bit   rsp_quiet     = 1'b0;

   base64_stream_encoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_char  (rsp_last_char)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request and holds it until the block takes it. The payload stays put
   // while the block stalls. After acceptance the sender may idle before the next one;
   // with no gap, valid simply stays high and the next payload replaces this one.
   task send_byte(input logic [7:0] data, input logic fin);
      int gap;
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(data, fin);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (sender_quiet) begin
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: takes characters and checks them, and decides its stall for the next
   // cycle. It alternates between stretches that never stall and stretches with random
   // stalls. When the main flow raises hold_req it stalls for HoldCycles in a row, which
   // lets the two-entry queue fill so that the block must push back on its requests.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_char(rsp_out_char, rsp_last_char);
      end
      if (rsp_mode_left == 0) begin
         rsp_quiet = ($urandom_range(0, 3) == 0);
         rsp_mode_left = $urandom_range(20, 200);
      end else begin
         rsp_mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HoldCycles;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (!rsp_quiet) begin
         stall_left = pick_gap();
      end
      rsp_stall <= (hold_left > 0) || (stall_left > 0);
   end

   // Watchdog: a correct block moves a request or a character well within IdleLimit.
   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int         sent;
      int         msg_len;
      logic [7:0] data;
      int         r;
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= 8'h00;
      req_final_byte <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed messages. A lone final byte ends a group at its start and gets "==".
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // A final second byte gets a single pad.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      // A final third byte completes the group and needs no pad.
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // A full ordinary group, then a final byte at the start of the next group.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      // Ordinary bytes in every phase, then a final byte in the middle of a group.
      send_byte(8'h3E, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);

      // Random messages. Lengths are mostly short so that each pad case comes up often,
      // with some long runs of full groups. Halfway through, the receiver holds off for a
      // long time while the sender keeps offering requests back to back.
      sent = 0;
      while (sent < RandomBytes) begin
         r = $urandom_range(0, 9);
         msg_len = (r == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
         sender_quiet = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < msg_len; k++) begin
            if (sent == RandomBytes / 2) begin
               hold_req = 1'b1;
               burst_left = 40;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
               data = 8'h00;
            end else if (r == 1) begin
               data = 8'hFF;
            end else begin
               data = 8'($urandom_range(0, 255));
            end
            send_byte(data, k == msg_len - 1);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Drain, then give a stray extra character time to show up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
